### hdl/mbalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbalu_pkg
// Shared types and constants of the multi-byte integer ALU.
// ----------------------------------------------------------------------------
package mbalu_pkg;

  localparam int unsigned DATA_W       = 64;
  localparam int unsigned HALF_W       = DATA_W / 2;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned NUM_BYTES    = DATA_W / BYTE_W;
  localparam int unsigned ACT_W        = 4;
  localparam int unsigned SIZE_W       = 4;
  localparam int unsigned MAX_BYTES_DF = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_INC = 4'd2,
    ACT_DEC = 4'd3,
    ACT_EQ  = 4'd4,
    ACT_NE  = 4'd5,
    ACT_GT  = 4'd6,
    ACT_LT  = 4'd7,
    ACT_GE  = 4'd8,
    ACT_LE  = 4'd9
  } action_e;

  // advance enables of the two adder stages
  typedef struct packed {
    logic lo_en;
    logic hi_en;
  } add_en_t;

  // control carried alongside the operands
  typedef struct packed {
    action_e           act;
    logic              bad;
    logic [DATA_W-1:0] mask;
  } ctrl_t;

endpackage

### hdl/mbalu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbalu_req_if / mbalu_rsp_if
// Valid/ready channels for ALU requests and results.
// ----------------------------------------------------------------------------
interface mbalu_req_if;
  import mbalu_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [DATA_W-1:0]   first_operand;
  logic [DATA_W-1:0]   second_operand;
  logic [SIZE_W-1:0]   size_bytes;

  modport source (
    output valid, action, first_operand, second_operand, size_bytes,
    input  ready
  );
  modport sink (
    input  valid, action, first_operand, second_operand, size_bytes,
    output ready
  );
endinterface

interface mbalu_rsp_if;
  import mbalu_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   value;
  logic                compare_flag;
  logic                bad_action;

  modport source (
    output valid, value, compare_flag, bad_action,
    input  ready
  );
  modport sink (
    input  valid, value, compare_flag, bad_action,
    output ready
  );
endinterface

### hdl/multibyte_integer_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibyte_integer_alu_top
// Add, subtract, increment, decrement and compare on unsigned little-endian
// operands of 1 to MAX_BYTES bytes.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle unless the result stalls; four
//   register stages (decode, low-half add, high-half add, result select)
//   each advance independently
// a stalled result holds its stage while earlier stages keep filling
// reset clears the stage valid bits only; the datapath is not reset
module multibyte_integer_alu_top
  import mbalu_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbalu_req_if.sink   req_i,
  mbalu_rsp_if.source rsp_o
);

  localparam int unsigned NSTG = 4;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   free;
  add_en_t         add_en;

  // stage k may load when empty or when its content moves on
  assign free[NSTG] = rsp_o.ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_free
    assign free[k] = !vld_q[k] || free[k+1];
  end

  assign req_i.ready = free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (free[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (free[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: decode, mask, operand select
  logic [SIZE_W-1:0] size_sat;
  logic [DATA_W-1:0] mask_d;
  logic [DATA_W-1:0] a_m, b_m;
  logic [DATA_W-1:0] x_d, y_d;
  logic              cin_d;
  ctrl_t             ctrl_d;

  assign size_sat = (req_i.size_bytes > SIZE_W'(MAX_BYTES)) ? SIZE_W'(MAX_BYTES)
                                                             : req_i.size_bytes;

  for (genvar b = 0; b < NUM_BYTES; b++) begin : g_mask
    assign mask_d[b*BYTE_W +: BYTE_W] = {BYTE_W{SIZE_W'(b) < size_sat}};
  end

  assign a_m = req_i.first_operand & mask_d;
  assign b_m = req_i.second_operand & mask_d;

  always_comb begin
    x_d        = b_m;
    y_d        = ~a_m;
    cin_d      = 1'b1;
    ctrl_d.act = action_e'(req_i.action);
    ctrl_d.bad = 1'b0;
    ctrl_d.mask = mask_d;
    case (req_i.action)
      ACT_ADD: begin
        y_d   = a_m;
        cin_d = 1'b0;
      end
      ACT_INC: begin
        x_d   = a_m;
        y_d   = DATA_W'(1);
        cin_d = 1'b0;
      end
      ACT_DEC: begin
        // a - 1 as a + ~1 + 1
        x_d   = a_m;
        y_d   = ~DATA_W'(1);
        cin_d = 1'b1;
      end
      ACT_SUB, ACT_EQ, ACT_NE, ACT_GT, ACT_LT, ACT_GE, ACT_LE: begin
        // second minus first; carry out means second >= first
        x_d   = b_m;
        y_d   = ~a_m;
        cin_d = 1'b1;
      end
      default: begin
        ctrl_d.bad = 1'b1;
      end
    endcase
  end

  logic [DATA_W-1:0] x_q, y_q;
  logic              cin_q;
  ctrl_t             ctrl1_q, ctrl2_q, ctrl3_q;

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      x_q     <= x_d;
      y_q     <= y_d;
      cin_q   <= cin_d;
      ctrl1_q <= ctrl_d;
    end
    if (free[1]) begin
      ctrl2_q <= ctrl1_q;
    end
    if (free[2]) begin
      ctrl3_q <= ctrl2_q;
    end
  end

  // ---------------- stages 2 and 3: split add
  logic [DATA_W-1:0] sum;
  logic              cout;

  assign add_en.lo_en = free[1];
  assign add_en.hi_en = free[2];

  mbalu_adder u_adder (
    .clk_i  (clk_i),
    .en_i   (add_en),
    .x_i    (x_q),
    .y_i    (y_q),
    .cin_i  (cin_q),
    .sum_o  (sum),
    .cout_o (cout)
  );

  // ---------------- stage 4: result select
  logic [DATA_W-1:0] value_d, value_q;
  logic              flag_d, flag_q;
  logic              bad_q;
  logic              zero;

  assign zero = (sum == '0);

  always_comb begin
    value_d = '0;
    flag_d  = 1'b0;
    if (!ctrl3_q.bad) begin
      case (ctrl3_q.act)
        ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: value_d = sum & ctrl3_q.mask;
        ACT_EQ:  flag_d = zero;
        ACT_NE:  flag_d = !zero;
        ACT_GT:  flag_d = cout && !zero;
        ACT_LT:  flag_d = !cout;
        ACT_GE:  flag_d = cout;
        ACT_LE:  flag_d = !cout || zero;
        default: flag_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[3]) begin
      value_q <= value_d;
      flag_q  <= flag_d;
      bad_q   <= ctrl3_q.bad;
    end
  end

  assign rsp_o.valid        = vld_q[NSTG-1];
  assign rsp_o.value        = value_q;
  assign rsp_o.compare_flag = flag_q;
  assign rsp_o.bad_action   = bad_q;

endmodule

### hdl/mbalu_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbalu_adder
// Two-stage 64-bit adder: low half in the first stage, high half with the
// carry in the second. Gives the sum and the carry out of the top bit.
// ----------------------------------------------------------------------------
module mbalu_adder
  import mbalu_pkg::*;
(
  input  logic              clk_i,
  input  add_en_t           en_i,
  input  logic [DATA_W-1:0] x_i,
  input  logic [DATA_W-1:0] y_i,
  input  logic              cin_i,
  output logic [DATA_W-1:0] sum_o,
  output logic              cout_o
);

  logic [HALF_W-1:0] lo_sum_d, lo_sum_q;
  logic              lo_c_d, lo_c_q;
  logic [HALF_W-1:0] x_hi_q, y_hi_q;
  logic [HALF_W-1:0] hi_sum_d;
  logic              hi_c_d;
  logic [DATA_W-1:0] sum_q;
  logic              cout_q;

  assign {lo_c_d, lo_sum_d} = {1'b0, x_i[HALF_W-1:0]} + {1'b0, y_i[HALF_W-1:0]}
                              + {{HALF_W{1'b0}}, cin_i};
  assign {hi_c_d, hi_sum_d} = {1'b0, x_hi_q} + {1'b0, y_hi_q}
                              + {{HALF_W{1'b0}}, lo_c_q};

  always_ff @(posedge clk_i) begin
    if (en_i.lo_en) begin
      lo_sum_q <= lo_sum_d;
      lo_c_q   <= lo_c_d;
      x_hi_q   <= x_i[DATA_W-1:HALF_W];
      y_hi_q   <= y_i[DATA_W-1:HALF_W];
    end
    if (en_i.hi_en) begin
      sum_q  <= {hi_sum_d, lo_sum_q};
      cout_q <= hi_c_d;
    end
  end

  assign sum_o  = sum_q;
  assign cout_o = cout_q;

endmodule
